[rtl/cfp_pkg.sv]
// cfp_pkg: shared types, constants and the CRC-16 byte update for the packet framer.
// Used by every module under crc_framed_packet_builder. No dependencies.
package cfp_pkg;

    // Input item kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_START_MAGIC_FIRST  = 2'd0;
    localparam logic [1:0] REG_START_MAGIC_SECOND = 2'd1;
    localparam logic [1:0] REG_END_MAGIC_FIRST    = 2'd2;
    localparam logic [1:0] REG_END_MAGIC_SECOND   = 2'd3;

    // Serialiser step numbers: header 0..10, trailer 11..14
    localparam logic [3:0] STEP_FIRST     = 4'd0;
    localparam logic [3:0] STEP_HDR_END   = 4'd10;
    localparam logic [3:0] STEP_CRC_HI    = 4'd11;
    localparam logic [3:0] STEP_CRC_LO    = 4'd12;
    localparam logic [3:0] STEP_END_FIRST = 4'd13;
    localparam logic [3:0] STEP_LAST      = 4'd14;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_type;
        logic [15:0] seq_num;
        logic [31:0] time_stamp;
        logic [15:0] frame_length;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_frame;
    } t_out_item;

    // Command passed from the front end to the serialiser
    typedef struct packed {
        logic        is_payload;   // single payload byte, else a header
        logic        trailer;      // close the frame after this command
        logic [7:0]  frame_type;
        logic [15:0] seq_num;
        logic [31:0] time_stamp;
        logic [15:0] frame_length;
        logic [7:0]  data_byte;
    } t_cmd;

    typedef struct packed {
        logic [7:0] start_first;
        logic [7:0] start_second;
        logic [7:0] end_first;
        logic [7:0] end_second;
    } t_magic;

    // One byte through the MSB-first CRC, bit at a time
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/cfp_front.sv]
// cfp_front: accepts input items, tracks the open frame and turns them into commands.
// Depends on cfp_pkg. Feeds cfp_queue.
module cfp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cfp_pkg::t_in_item i_in_data,
    input  logic              i_q_full,
    output logic              o_push,
    output cfp_pkg::t_cmd     o_cmd
);

    logic        r_open;
    logic        n_open;
    logic [15:0] r_left;
    logic [15:0] n_left;
    logic        accept;
    logic        is_start;
    logic        len_zero;
    logic        last_payload;

    assign o_in_ready   = !i_q_full;
    assign accept       = i_in_valid && !i_q_full;
    assign is_start     = (i_in_data.kind == cfp_pkg::KIND_START);
    assign len_zero     = (i_in_data.frame_length == 16'd0);
    assign last_payload = (r_left == 16'd1);

    // Classify: starts only when closed, payload only when open; others dropped
    always_comb begin
        n_open = r_open;
        n_left = r_left;
        o_push = 1'b0;
        o_cmd  = '0;
        o_cmd.frame_type   = i_in_data.frame_type;
        o_cmd.seq_num      = i_in_data.seq_num;
        o_cmd.time_stamp   = i_in_data.time_stamp;
        o_cmd.frame_length = i_in_data.frame_length;
        o_cmd.data_byte    = i_in_data.data_byte;
        if (accept) begin
            if (is_start && !r_open) begin
                o_push           = 1'b1;
                o_cmd.is_payload = 1'b0;
                o_cmd.trailer    = len_zero;
                n_open           = !len_zero;
                n_left           = i_in_data.frame_length;
            end else if (!is_start && r_open) begin
                o_push           = 1'b1;
                o_cmd.is_payload = 1'b1;
                o_cmd.trailer    = last_payload;
                n_left           = r_left - 16'd1;
                n_open           = !last_payload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= 16'd0;
        end else begin
            r_open <= n_open;
            r_left <= n_left;
        end
    end

endmodule

[rtl/cfp_queue.sv]
// cfp_queue: small command FIFO between the front end and the serialiser.
// Depends on cfp_pkg for the command type.
module cfp_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cfp_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output cfp_pkg::t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

    cfp_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    assign o_full  = (r_count == CNT_MAX);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_MAX) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_MAX) ? '0 : r_rd_ptr + PW'(1);
            end
            r_count <= n_count;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CNT_MAX))
        else $error("queue pushed while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("queue fill level out of range");

endmodule

[rtl/cfp_back.sv]
// cfp_back: serialiser; steps through header, payload and trailer bytes, runs the CRC,
// and drives the output register. Depends on cfp_pkg.
module cfp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfp_pkg::t_magic    i_magic,
    input  logic               i_q_valid,
    input  cfp_pkg::t_cmd      i_q_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cfp_pkg::t_out_item o_out_data
);

    cfp_pkg::t_cmd      r_cmd;
    logic               r_busy;
    logic [3:0]         r_step;
    logic [15:0]        r_crc;
    logic               r_out_valid;
    cfp_pkg::t_out_item r_out_data;

    logic        load;
    logic        fire;
    logic        step_done;
    logic        covered;
    logic        is_last;
    logic [7:0]  cur_byte;
    logic [15:0] crc_base;
    logic [3:0]  n_step;

    assign load    = !r_out_valid || i_out_ready;
    assign fire    = r_busy && load;
    assign covered = (r_step <= cfp_pkg::STEP_HDR_END);
    assign is_last = (r_step == cfp_pkg::STEP_LAST);

    // End of the current command
    always_comb begin
        if (r_cmd.trailer) begin
            step_done = is_last;
        end else if (r_cmd.is_payload) begin
            step_done = (r_step == cfp_pkg::STEP_FIRST);
        end else begin
            step_done = (r_step == cfp_pkg::STEP_HDR_END);
        end
    end

    assign o_pop = i_q_valid && (!r_busy || (fire && step_done));

    // Payload skips straight from its byte to the trailer
    assign n_step = (r_cmd.is_payload && r_step == cfp_pkg::STEP_FIRST)
                    ? cfp_pkg::STEP_CRC_HI : r_step + 4'd1;

    // Byte select
    always_comb begin
        unique case (r_step)
            4'd0:  cur_byte = r_cmd.is_payload ? r_cmd.data_byte : i_magic.start_first;
            4'd1:  cur_byte = i_magic.start_second;
            4'd2:  cur_byte = r_cmd.frame_type;
            4'd3:  cur_byte = r_cmd.seq_num[15:8];
            4'd4:  cur_byte = r_cmd.seq_num[7:0];
            4'd5:  cur_byte = r_cmd.time_stamp[31:24];
            4'd6:  cur_byte = r_cmd.time_stamp[23:16];
            4'd7:  cur_byte = r_cmd.time_stamp[15:8];
            4'd8:  cur_byte = r_cmd.time_stamp[7:0];
            4'd9:  cur_byte = r_cmd.frame_length[15:8];
            4'd10: cur_byte = r_cmd.frame_length[7:0];
            4'd11: cur_byte = r_crc[15:8];
            4'd12: cur_byte = r_crc[7:0];
            4'd13: cur_byte = i_magic.end_first;
            4'd14: cur_byte = i_magic.end_second;
            default: cur_byte = 8'h00;
        endcase
    end

    // A header restarts the CRC at its first byte
    assign crc_base = (!r_cmd.is_payload && r_step == cfp_pkg::STEP_FIRST)
                      ? cfp_pkg::CRC_INIT : r_crc;

    // Command register and step counter
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= cfp_pkg::STEP_FIRST;
            r_crc  <= cfp_pkg::CRC_INIT;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= cfp_pkg::STEP_FIRST;
            end else if (fire && step_done) begin
                r_busy <= 1'b0;
            end else if (fire) begin
                r_step <= n_step;
            end
            if (fire) begin
                if (is_last) begin
                    r_crc <= cfp_pkg::CRC_INIT;
                end else if (covered) begin
                    r_crc <= cfp_pkg::crc_update(crc_base, cur_byte);
                end
            end
        end
    end

    // Output register: one transfer per cycle when the sink keeps up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data.out_byte      <= cur_byte;
            r_out_data.last_of_frame <= is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= cfp_pkg::STEP_LAST))
        else $error("serialiser step out of range");

    a_payload_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cmd.is_payload) |->
            (r_step == cfp_pkg::STEP_FIRST || r_step >= cfp_pkg::STEP_CRC_HI))
        else $error("payload command inside header steps");

    a_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && is_last) |=> (r_crc == cfp_pkg::CRC_INIT))
        else $error("CRC not restarted after frame end");

endmodule

[rtl/crc_framed_packet_builder.sv]
// crc_framed_packet_builder: top level of the CRC-16 packet framer.
// Depends on cfp_pkg, cfp_front, cfp_queue and cfp_back.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+---------------------
//  in      | sink      | i_in_valid / o_in_ready     | i_in_data  (t_in_item)
//  out     | source    | o_out_valid / i_out_ready   | o_out_data (t_out_item)
//  cfg     | sink      | i_cfg_wr_en, no wait        | i_cfg_index, i_cfg_wdata
//
// A payload byte is one output byte, so payload streams at one item per cycle while
// the sink keeps up. A start item yields 11 header bytes (15 if the length is zero)
// and a closing payload byte yields 5.
// Input is taken while the command queue (QUEUE_DEPTH entries) has room; the output
// register holds a byte until the sink takes it. Reset is synchronous, active low,
// and clears the frame tracking, queue, serialiser and magic registers.
module crc_framed_packet_builder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cfp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cfp_pkg::t_out_item o_out_data,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_wdata
);

    cfp_pkg::t_magic r_magic;
    cfp_pkg::t_cmd   push_cmd;
    cfp_pkg::t_cmd   q_cmd;
    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            pop;

    // Magic byte registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                cfp_pkg::REG_START_MAGIC_FIRST:  r_magic.start_first  <= i_cfg_wdata;
                cfp_pkg::REG_START_MAGIC_SECOND: r_magic.start_second <= i_cfg_wdata;
                cfp_pkg::REG_END_MAGIC_FIRST:    r_magic.end_first    <= i_cfg_wdata;
                cfp_pkg::REG_END_MAGIC_SECOND:   r_magic.end_second   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    cfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    cfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    cfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_magic     (r_magic),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[verif/tb_crc_framed_packet_builder.sv]
// tb_crc_framed_packet_builder: self-checking testbench for the CRC-16 packet framer.
// Depends on cfp_pkg and crc_framed_packet_builder; predicts every output byte itself
// and checks each output transfer against the oldest predicted byte.
module tb_crc_framed_packet_builder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 500000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_AT       = 60;    // input transfers seen before the long sink hold
    localparam int HOLD_CYCLES   = 400;

    typedef struct {
        cfp_pkg::t_in_item item;
        bit                drain;    // wait for every owed byte before offering this item
    } t_feed;

    // DUT connections
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    cfp_pkg::t_in_item  i_in_data   = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    cfp_pkg::t_out_item o_out_data;
    logic               i_cfg_wr_en = 1'b0;
    logic [1:0]         i_cfg_index = cfp_pkg::REG_START_MAGIC_FIRST;
    logic [7:0]         i_cfg_wdata = 8'h00;

    // Stimulus and expected bytes
    t_feed              feed_q[$];
    cfp_pkg::t_out_item owed_bytes[$];
    int                 owed_count  = 0;
    int                 in_xfers    = 0;
    int                 err_count   = 0;
    int                 cycles      = 0;

    // Framer model state
    cfp_pkg::t_magic magic      = '0;
    logic [15:0]     crc_run    = cfp_pkg::CRC_INIT;
    logic [15:0]     bytes_left = '0;
    logic            in_frame   = 1'b0;

    // Sender burst and receiver pattern state
    int          burst_left = 0;
    int          gap_left   = 0;
    int          hold_left  = 0;
    bit          hold_done  = 1'b0;
    logic [15:0] stall_mask = '1;
    logic [3:0]  pat_pos    = '0;

    crc_framed_packet_builder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // CRC-16/CCITT-FALSE, whole byte at once
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [7:0] x;
        x = c[15:8] ^ b;
        x = x ^ (x >> 4);
        return {c[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
    endfunction

    function automatic void owe_byte(input logic [7:0] b, input bit covered, input bit last);
        cfp_pkg::t_out_item r;
        r.out_byte      = b;
        r.last_of_frame = last;
        owed_bytes.push_back(r);
        if (covered) begin
            crc_run = crc16_byte(crc_run, b);
        end
    endfunction

    // CRC high then low, end markers, frame closes
    function automatic void owe_trailer();
        logic [15:0] c;
        c = crc_run;
        owe_byte(c[15:8], 1'b0, 1'b0);
        owe_byte(c[7:0], 1'b0, 1'b0);
        owe_byte(magic.end_first, 1'b0, 1'b0);
        owe_byte(magic.end_second, 1'b0, 1'b1);
        in_frame   = 1'b0;
        bytes_left = '0;
        crc_run    = cfp_pkg::CRC_INIT;
    endfunction

    // Works out the bytes one accepted input item causes
    function automatic void frame_predict(input cfp_pkg::t_in_item it);
        if (it.kind == cfp_pkg::KIND_START) begin
            if (in_frame) begin
                return;
            end
            crc_run = cfp_pkg::CRC_INIT;
            owe_byte(magic.start_first, 1'b1, 1'b0);
            owe_byte(magic.start_second, 1'b1, 1'b0);
            owe_byte(it.frame_type, 1'b1, 1'b0);
            owe_byte(it.seq_num[15:8], 1'b1, 1'b0);
            owe_byte(it.seq_num[7:0], 1'b1, 1'b0);
            owe_byte(it.time_stamp[31:24], 1'b1, 1'b0);
            owe_byte(it.time_stamp[23:16], 1'b1, 1'b0);
            owe_byte(it.time_stamp[15:8], 1'b1, 1'b0);
            owe_byte(it.time_stamp[7:0], 1'b1, 1'b0);
            owe_byte(it.frame_length[15:8], 1'b1, 1'b0);
            owe_byte(it.frame_length[7:0], 1'b1, 1'b0);
            if (it.frame_length == '0) begin
                owe_trailer();
            end else begin
                in_frame   = 1'b1;
                bytes_left = it.frame_length;
            end
        end else if (in_frame) begin
            owe_byte(it.data_byte, 1'b1, 1'b0);
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == '0) begin
                owe_trailer();
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // Input side: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin
        t_feed nxt;
        if (i_rst_n && (!i_in_valid || o_in_ready)) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (feed_q.size() == 0 ||
                         (feed_q[0].drain && (i_in_valid || owed_count != 0))) begin
                i_in_valid <= 1'b0;
            end else begin
                nxt = feed_q.pop_front();
                i_in_data  <= nxt.item;
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Output side: one long hold, otherwise a rotating stall mask
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && in_xfers >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            if (pat_pos == 4'hF) begin
                case ($urandom_range(0, 3))
                    0:       stall_mask <= '1;
                    1:       stall_mask <= 16'($urandom);
                    2:       stall_mask <= 16'($urandom | $urandom);
                    default: stall_mask <= 16'($urandom & $urandom);
                endcase
            end
            pat_pos     <= pat_pos + 4'd1;
            i_out_ready <= stall_mask[pat_pos];
        end
    end

    // Predict on input transfers, check on output transfers
    always @(posedge i_clk) begin
        cfp_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                frame_predict(i_in_data);
                in_xfers <= in_xfers + 1;
            end
            if (o_out_valid && i_out_ready) begin
                if (owed_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last %b",
                                              o_out_data.out_byte, o_out_data.last_of_frame));
                end else begin
                    want = owed_bytes.pop_front();
                    if (o_out_data.out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  o_out_data.out_byte, want.out_byte));
                    end
                    if (o_out_data.last_of_frame !== want.last_of_frame) begin
                        report_mismatch($sformatf("last_of_frame %b, expected %b",
                                                  o_out_data.last_of_frame,
                                                  want.last_of_frame));
                    end
                end
            end
            owed_count <= owed_bytes.size();
        end
    end

    // Watchdog
    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic cfp_pkg::t_in_item mk_start(input logic [7:0] ftype,
                                                   input logic [15:0] seq,
                                                   input logic [31:0] ts,
                                                   input logic [15:0] len);
        cfp_pkg::t_in_item it;
        it.kind         = cfp_pkg::KIND_START;
        it.frame_type   = ftype;
        it.seq_num      = seq;
        it.time_stamp   = ts;
        it.frame_length = len;
        it.data_byte    = 8'($urandom);
        return it;
    endfunction

    // Header fields carry noise, the block must ignore them
    function automatic cfp_pkg::t_in_item mk_payload(input logic [7:0] b);
        cfp_pkg::t_in_item it;
        it.kind         = cfp_pkg::KIND_PAYLOAD;
        it.frame_type   = 8'($urandom);
        it.seq_num      = 16'($urandom);
        it.time_stamp   = $urandom;
        it.frame_length = 16'($urandom);
        it.data_byte    = b;
        return it;
    endfunction

    function automatic void queue_item(input cfp_pkg::t_in_item it, input bit drain);
        t_feed f;
        f.item  = it;
        f.drain = drain;
        feed_q.push_back(f);
    endfunction

    // One frame; a noisy one gets dropped starts mixed into its payload
    task automatic queue_frame(input int len, input bit noisy, input bit drain);
        queue_item(mk_start(8'($urandom), 16'($urandom), $urandom, 16'(len)), drain);
        for (int k = 0; k < len; k++) begin
            if (noisy && $urandom_range(0, 7) == 0) begin
                queue_item(mk_start(8'($urandom), 16'($urandom), $urandom, 16'($urandom)),
                           1'b0);
            end
            queue_item(mk_payload(8'($urandom)), 1'b0);
        end
    endtask

    task automatic random_phase(input int n_items, input bit drains);
        int done;
        int len;
        done = 0;
        while (done < n_items) begin
            case ($urandom_range(0, 19))
                0:       len = 0;
                1:       len = $urandom_range(17, 48);
                default: len = $urandom_range(1, 12);
            endcase
            // stray payload between frames
            if ($urandom_range(0, 9) == 0) begin
                queue_item(mk_payload(8'($urandom)), 1'b0);
            end
            queue_frame(len, $urandom_range(0, 4) == 0, drains && $urandom_range(0, 3) == 0);
            done += len + 1;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            cfp_pkg::REG_START_MAGIC_FIRST:  magic.start_first  = val;
            cfp_pkg::REG_START_MAGIC_SECOND: magic.start_second = val;
            cfp_pkg::REG_END_MAGIC_FIRST:    magic.end_first    = val;
            default:                         magic.end_second   = val;
        endcase
    endtask

    task automatic set_magics(input logic [7:0] sf, input logic [7:0] ss,
                              input logic [7:0] ef, input logic [7:0] es);
        write_reg(cfp_pkg::REG_START_MAGIC_FIRST, sf);
        write_reg(cfp_pkg::REG_START_MAGIC_SECOND, ss);
        write_reg(cfp_pkg::REG_END_MAGIC_FIRST, ef);
        write_reg(cfp_pkg::REG_END_MAGIC_SECOND, es);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // Idle: nothing left to send or owed, then let any dropped item drain through
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (feed_q.size() != 0 || i_in_valid || owed_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Main sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: drops, zero-length frames, field extremes, start inside a frame
        set_magics(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_item(mk_payload(8'hFF), 1'b0);
        queue_item(mk_start(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000), 1'b0);
        queue_item(mk_start(8'h00, 16'h0000, 32'h0000_0000, 16'h0000), 1'b0);
        queue_item(mk_start(8'h5A, 16'h8001, 32'h8000_0001, 16'h0001), 1'b0);
        queue_item(mk_payload(8'h00), 1'b0);
        queue_item(mk_start(8'h00, 16'h1234, 32'h0102_0304, 16'h0003), 1'b0);
        queue_item(mk_payload(8'hFF), 1'b0);
        queue_item(mk_start(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF), 1'b0);
        queue_item(mk_payload(8'h00), 1'b0);
        queue_item(mk_payload(8'hA5), 1'b0);
        queue_item(mk_payload(8'h00), 1'b0);
        queue_item(mk_start(8'h81, 16'h7FFE, 32'h7FFF_FFFE, 16'h0005), 1'b0);
        queue_item(mk_payload(8'h00), 1'b0);
        queue_item(mk_payload(8'hFF), 1'b0);
        queue_item(mk_payload(8'h80), 1'b0);
        queue_item(mk_payload(8'h01), 1'b0);
        queue_item(mk_payload(8'h7F), 1'b0);
        wait_idle();

        // Long receiver hold lands in this phase
        set_magics(8'h00, 8'h00, 8'h00, 8'h00);
        random_phase(70, 1'b0);
        wait_idle();

        set_magics(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        random_phase(100, 1'b0);
        wait_idle();

        // Sender pauses for owed bytes; finish on a maximum-length header left open
        set_magics(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        random_phase(60, 1'b1);
        queue_item(mk_start(8'($urandom), 16'($urandom), $urandom, 16'hFFFF), 1'b1);
        for (int k = 0; k < 5; k++) begin
            queue_item(mk_payload(8'($urandom)), 1'b0);
        end
        wait_idle();

        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
